// File: rtl/core/vst_pkg.sv
// Shared constants, codes and types of the visible span tracker.
`timescale 1ns / 1ps
`default_nettype none

package vst_pkg;

  // Table geometry.
  localparam int unsigned TILE_DEPTH = 256;
  localparam int unsigned ADDR_W     = $clog2(TILE_DEPTH);
  localparam int unsigned CNT_W      = ADDR_W + 1;

  // Field widths.
  localparam int unsigned LEFT_W  = 16;
  localparam int unsigned WIDTH_W = 12;
  localparam int unsigned HVW_W   = 12;
  localparam int unsigned CFG_W   = 12;
  // Window positions: a signed left edge plus up to two 12-bit offsets.
  localparam int unsigned POS_W   = 18;

  // Configuration register indexes and reset values.
  localparam logic [0:0]       CFG_HALF_VIEW  = 1'b0;
  localparam logic [0:0]       CFG_TILE_COUNT = 1'b1;
  localparam logic [HVW_W-1:0] HVW_RESET      = 12'd320;

  // Item commands; the remaining code is a no-op.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_SLIDE = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GROW_RD,
    ST_GROW_EV,
    ST_SHRINK_RD,
    ST_SHRINK_EV,
    ST_FINISH
  } state_e;

  // One table entry.
  typedef struct packed {
    logic signed [LEFT_W-1:0] left;
    logic [WIDTH_W-1:0]       width;
  } tile_t;

  // Access request from the sequencer to the tile memory.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    tile_t             wr_tile;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Result of one item.
  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic              empty;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/visible_span_tracker.sv
// Top level of the visible span tracker: ports, configuration and result register.
//
// Input items arrive on the s_axis stream, one command per transfer selected by
// s_axis_tuser: load a tile into the table, scan the table for the tiles that
// overlap the view window, or slide the current span after the viewer moved.
// Every item produces exactly one result transfer on m_axis carrying the first
// and last visible tile indexes, with tuser flagging an empty view.
// Configuration (half view width, tile count) is written through cfg_we_i. The user
// must write it only while the block is idle; the block itself does not enforce it.
// Written so, it takes effect for the next item. A load, a no-op or a slide on an
// empty view goes from acceptance straight to the finish state. A full scan reads
// the table one entry per cycle over the usable tiles, testing each on its registered
// read data. A slide reads and then tests each tile it examines in separate states.
// One item is in work at a time; the next transfer is taken at the earliest in the
// cycle in which the result turns valid. s_axis_tready is high whenever the
// sequencer is idle, even while a result waits in the output register.
// A stalled receiver holds the result register and, once a second result is
// ready, holds the sequencer. After reset the view is empty with both bounds at
// zero, the half view width is 320 and the tile count is 0. Table contents are
// undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module visible_span_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tile_slot[7:0], tile_left[23:8], tile_width[35:24], viewer_left[51:36],
  // viewer_width[63:52], moving_right[64], zero fill[71:65]
  input  logic [71:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // first_visible[7:0], last_visible[15:8]
  output logic [15:0] m_axis_tdata,
  // view_empty[0]
  output logic [0:0]  m_axis_tuser
);
  import vst_pkg::*;

  logic [HVW_W-1:0] hvw_q;
  logic [CNT_W-1:0] tile_count_q;
  logic [CNT_W-1:0] count_use;

  logic     in_accept;
  cmd_e     in_cmd;
  tile_t    in_tile;
  logic     ctrl_ready;
  mem_req_t mem_req;
  tile_t    rd_tile;
  logic     overlap;
  logic     result_load;
  result_t  result;
  logic     out_free;
  logic     out_valid_q;
  result_t  out_res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvw_q        <= HVW_RESET;
      tile_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HALF_VIEW:  hvw_q        <= cfg_data_i[HVW_W-1:0];
        CFG_TILE_COUNT: tile_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Usable tile count is clipped to the table depth.
  assign count_use = (tile_count_q > CNT_W'(TILE_DEPTH)) ? CNT_W'(TILE_DEPTH) : tile_count_q;

  // Input transfer decode.
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_tile.left  = s_axis_tdata[23:8];
  assign in_tile.width = s_axis_tdata[35:24];
  assign s_axis_tready = ctrl_ready;

  vst_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_accept),
    .cmd_i          (in_cmd),
    .slot_i         (s_axis_tdata[7:0]),
    .tile_i         (in_tile),
    .moving_right_i (s_axis_tdata[64]),
    .count_i        (count_use),
    .overlap_i      (overlap),
    .out_free_i     (out_free),
    .ready_o        (ctrl_ready),
    .mem_req_o      (mem_req),
    .result_load_o  (result_load),
    .result_o       (result)
  );

  vst_tile_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_tile_o (rd_tile)
  );

  vst_window u_window (
    .clk_i             (clk_i),
    .capture_i         (in_accept),
    .viewer_left_i     (s_axis_tdata[51:36]),
    .viewer_width_i    (s_axis_tdata[63:52]),
    .half_view_width_i (hvw_q),
    .tile_i            (rd_tile),
    .overlap_o         (overlap)
  );

  // Output register decouples the receiver from the sequencer.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.last, out_res_q.first};
  assign m_axis_tuser  = out_res_q.empty;

endmodule

`default_nettype wire

// File: rtl/core/vst_tile_ram.sv
// Tile table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module vst_tile_ram (
  input  logic             clk_i,
  input  vst_pkg::mem_req_t req_i,
  output vst_pkg::tile_t    rd_tile_o
);
  import vst_pkg::*;

  tile_t mem_q [TILE_DEPTH];
  tile_t rd_tile_q;

  // Synchronous write and read; the sequencer never reads and writes in one cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_tile;
    end
    if (req_i.rd_en) begin
      rd_tile_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_tile_o = rd_tile_q;

endmodule

`default_nettype wire

// File: rtl/core/vst_window.sv
// View window bounds and the overlap test of one tile against them.
`timescale 1ns / 1ps
`default_nettype none

module vst_window (
  input  logic                               clk_i,
  input  logic                               capture_i,
  input  logic signed [vst_pkg::LEFT_W-1:0]  viewer_left_i,
  input  logic [vst_pkg::WIDTH_W-1:0]        viewer_width_i,
  input  logic [vst_pkg::HVW_W-1:0]          half_view_width_i,
  input  vst_pkg::tile_t                     tile_i,
  output logic                               overlap_o
);
  import vst_pkg::*;

  logic [POS_W-1:0]        centre_d;
  logic [POS_W-1:0]        centre_q;
  logic [POS_W-1:0]        hvw_ext;
  logic signed [POS_W-1:0] lo_q;
  logic signed [POS_W-1:0] hi_q;
  logic signed [POS_W-1:0] tile_l;
  logic signed [POS_W-1:0] tile_r;

  // Viewer centre: left edge plus half the width, truncated.
  assign centre_d = {{(POS_W-LEFT_W){viewer_left_i[LEFT_W-1]}}, viewer_left_i}
                  + {{(POS_W-WIDTH_W+1){1'b0}}, viewer_width_i[WIDTH_W-1:1]};
  assign hvw_ext  = {{(POS_W-HVW_W){1'b0}}, half_view_width_i};

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      centre_q <= centre_d;
    end
  end

  // Window edges follow the centre in the next cycle; both stay put while busy.
  always_ff @(posedge clk_i) begin
    lo_q <= $signed(centre_q - hvw_ext);
    hi_q <= $signed(centre_q + hvw_ext);
  end

  // A tile overlaps when its right edge passes lo and its left edge is below hi.
  assign tile_l    = $signed({{(POS_W-LEFT_W){tile_i.left[LEFT_W-1]}}, tile_i.left});
  assign tile_r    = tile_l + $signed({{(POS_W-WIDTH_W){1'b0}}, tile_i.width});
  assign overlap_o = (tile_r > lo_q) && (tile_l < hi_q);

endmodule

`default_nettype wire

// File: rtl/core/vst_ctrl.sv
// Sequencer: loads, full scans and slide updates over the tile memory.
`timescale 1ns / 1ps
`default_nettype none

module vst_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  vst_pkg::cmd_e                    cmd_i,
  input  logic [vst_pkg::ADDR_W-1:0]       slot_i,
  input  vst_pkg::tile_t                   tile_i,
  input  logic                             moving_right_i,
  input  logic [vst_pkg::CNT_W-1:0]        count_i,
  input  logic                             overlap_i,
  input  logic                             out_free_i,
  output logic                             ready_o,
  output vst_pkg::mem_req_t                mem_req_o,
  output logic                             result_load_o,
  output vst_pkg::result_t                 result_o
);
  import vst_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] lower_q, lower_d;
  logic [ADDR_W-1:0] upper_q, upper_d;
  logic              empty_q, empty_d;
  logic              found_q, found_d;
  logic              right_q, right_d;
  logic [CNT_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_idx_q, pend_idx_d;

  logic              scan_issue;
  logic              grow_guard;
  logic [ADDR_W-1:0] grow_addr;
  logic              shrink_guard;
  logic [ADDR_W-1:0] shrink_addr;

  // Loop conditions and the index each step examines.
  assign scan_issue   = scan_cnt_q < count_i;
  assign grow_guard   = right_q ? (({1'b0, upper_q} + CNT_W'(1)) < count_i)
                                : (lower_q != '0);
  assign grow_addr    = right_q ? upper_q + ADDR_W'(1) : lower_q - ADDR_W'(1);
  assign shrink_guard = lower_q < upper_q;
  assign shrink_addr  = right_q ? lower_q : upper_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            CMD_LOAD:  state_d = ST_FINISH;
            CMD_SCAN:  state_d = ST_SCAN;
            CMD_SLIDE: state_d = empty_q ? ST_FINISH : ST_GROW_RD;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_issue && !pend_q) state_d = ST_FINISH;
      end
      ST_GROW_RD:   state_d = grow_guard ? ST_GROW_EV : ST_SHRINK_RD;
      ST_GROW_EV:   state_d = overlap_i ? ST_GROW_RD : ST_SHRINK_RD;
      ST_SHRINK_RD: state_d = shrink_guard ? ST_SHRINK_EV : ST_FINISH;
      ST_SHRINK_EV: state_d = overlap_i ? ST_FINISH : ST_SHRINK_RD;
      ST_FINISH: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    lower_d       = lower_q;
    upper_d       = upper_q;
    empty_d       = empty_q;
    found_d       = found_q;
    right_d       = right_q;
    scan_cnt_d    = scan_cnt_q;
    pend_d        = 1'b0;
    pend_idx_d    = pend_idx_q;
    mem_req_o     = '0;
    result_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          right_d = moving_right_i;
          if (cmd_i == CMD_LOAD) begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = slot_i;
            mem_req_o.wr_tile = tile_i;
          end
          if (cmd_i == CMD_SCAN) begin
            scan_cnt_d = '0;
            found_d    = 1'b0;
            lower_d    = '0;
            upper_d    = '0;
          end
        end
      end
      ST_SCAN: begin
        // Reads stream one index a cycle; each index is tested in the cycle after its read.
        mem_req_o.rd_en   = scan_issue;
        mem_req_o.rd_addr = scan_cnt_q[ADDR_W-1:0];
        scan_cnt_d        = scan_cnt_q + CNT_W'(scan_issue);
        pend_d            = scan_issue;
        pend_idx_d        = scan_cnt_q[ADDR_W-1:0];
        if (pend_q && overlap_i) begin
          if (!found_q) lower_d = pend_idx_q;
          upper_d = pend_idx_q;
          found_d = 1'b1;
        end
        if (!scan_issue && !pend_q) empty_d = !found_q;
      end
      ST_GROW_RD: begin
        mem_req_o.rd_en   = grow_guard;
        mem_req_o.rd_addr = grow_addr;
      end
      ST_GROW_EV: begin
        if (overlap_i) begin
          if (right_q) upper_d = upper_q + ADDR_W'(1);
          else         lower_d = lower_q - ADDR_W'(1);
        end
      end
      ST_SHRINK_RD: begin
        mem_req_o.rd_en   = shrink_guard;
        mem_req_o.rd_addr = shrink_addr;
      end
      ST_SHRINK_EV: begin
        if (!overlap_i) begin
          if (right_q) lower_d = lower_q + ADDR_W'(1);
          else         upper_d = upper_q - ADDR_W'(1);
        end
      end
      ST_FINISH: result_load_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lower_q    <= '0;
      upper_q    <= '0;
      empty_q    <= 1'b1;
      found_q    <= 1'b0;
      right_q    <= 1'b0;
      scan_cnt_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      lower_q    <= lower_d;
      upper_q    <= upper_d;
      empty_q    <= empty_d;
      found_q    <= found_d;
      right_q    <= right_d;
      scan_cnt_q <= scan_cnt_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
  end

  assign ready_o        = (state_q == ST_IDLE);
  assign result_o.first = lower_q;
  assign result_o.last  = upper_q;
  assign result_o.empty = empty_q;

`ifndef NO_ASSERTIONS
  // A live span never has its bounds crossed.
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !empty_q) |-> (lower_q <= upper_q))
    else $error("span bounds crossed");

  // An empty view keeps both bounds at zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && empty_q) |-> (lower_q == '0 && upper_q == '0))
    else $error("empty view with nonzero bounds");

  // Table writes happen only while no walk is reading the memory.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (state_q == ST_IDLE))
    else $error("table write during a walk");

  // The scan index never runs past the tile count.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_cnt_q <= count_i))
    else $error("scan index past tile count");

  // Handing over a result always frees the sequencer.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_load_o |=> (state_q == ST_IDLE))
    else $error("sequencer busy after result handover");
`endif

endmodule

`default_nettype wire
